// ----- hdl/ssd_pkg.sv -----
package ssd_pkg;

  // segment codes, segments a to g in bits 0 to 6, point in bit 7
  localparam logic [7:0] SEG_BLANK = 8'h00;
  localparam logic [7:0] SEG_MINUS = 8'h40;
  localparam logic [7:0] SEG_POINT = 8'h80;

  // magnitude from which the display shows overflow
  localparam logic [15:0] MAG_LIMIT = 16'd1000;

  // display positions
  localparam int unsigned  NUM_POS  = 4;
  localparam logic [1:0]   POS_LAST = 2'd3;

  // reciprocal multipliers for the decimal split
  localparam logic [5:0] RECIP_100 = 6'd41;   // x*41 >> 12 == x/100 for x < 1000
  localparam logic [7:0] RECIP_10  = 8'd205;  // x*205 >> 11 == x/10 for x < 100

  // after the input register
  typedef struct packed {
    logic       tenths;
    logic       neg;
    logic       ovf;
    logic [9:0] mag;
  } ssd_in_t;

  // after the hundreds step
  typedef struct packed {
    logic       tenths;
    logic       neg;
    logic       ovf;
    logic       lt10;
    logic       lt100;
    logic [3:0] hund;
    logic [6:0] rem;
  } ssd_hund_t;

  // after the tens step
  typedef struct packed {
    logic       tenths;
    logic       neg;
    logic       ovf;
    logic       lt10;
    logic       lt100;
    logic [3:0] hund;
    logic [3:0] tens;
    logic [3:0] ones;
  } ssd_dec_t;

  typedef logic [NUM_POS-1:0][7:0] ssd_pat_t;

  // decimal digit to segment code
  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

// ----- hdl/signed_number_to_seven_segment.sv -----
// channel  | valid     | stall      | payload
// in       | in_valid  | in_stall   | in_opcode, in_negative, in_magnitude
// out      | out_valid | out_stall  | out_digit_position, out_segment_pattern, out_last_digit
//
// each transaction in yields four transactions out, positions 0 to 3, one per cycle
// while out_stall is low; a new value is loaded only once the last digit has gone out
// stages: input register, hundreds multiply, tens multiply, pattern build, serialiser
// rst_n is synchronous; it empties every stage, no values are held over
// a stall freezes the stages behind it; the next value waits in the pipe meanwhile
module signed_number_to_seven_segment import ssd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic        in_negative,
  input  logic [15:0] in_magnitude,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_digit_position,
  output logic [7:0]  out_segment_pattern,
  output logic        out_last_digit
);

  logic     inp_v_r;
  ssd_in_t  inp_r;
  ssd_in_t  inp_nxt;
  logic     inp_rdy;
  logic     split_rdy;
  logic     dec_v;
  ssd_dec_t dec;
  logic     pat_rdy;
  logic     pat_v;
  ssd_pat_t pat;
  logic     ser_rdy;

  assign inp_rdy  = !inp_v_r || split_rdy;
  assign in_stall = !inp_rdy;

  // input register, overflow flagged here
  always_comb begin
    inp_nxt.tenths = in_opcode;
    inp_nxt.neg    = in_negative;
    inp_nxt.ovf    = (in_magnitude >= MAG_LIMIT);
    inp_nxt.mag    = in_magnitude[9:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inp_v_r <= 1'b0;
    end else if (inp_rdy) begin
      inp_v_r <= in_valid;
    end
    if (inp_rdy && in_valid) begin
      inp_r <= inp_nxt;
    end
  end

  // decimal split
  ssd_split u_split (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (inp_v_r),
    .in_ready  (split_rdy),
    .in_data   (inp_r),
    .out_valid (dec_v),
    .out_ready (pat_rdy),
    .out_data  (dec)
  );

  // segment patterns for all four positions
  ssd_pattern u_pattern (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dec_v),
    .in_ready  (pat_rdy),
    .in_data   (dec),
    .out_valid (pat_v),
    .out_ready (ser_rdy),
    .out_data  (pat)
  );

  // one digit per output transaction
  ssd_serial u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pat_v),
    .in_ready  (ser_rdy),
    .in_data   (pat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_pos   (out_digit_position),
    .out_seg   (out_segment_pattern),
    .out_last  (out_last_digit)
  );

endmodule

// ----- hdl/ssd_split.sv -----
module ssd_split import ssd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ssd_in_t   in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output ssd_dec_t  out_data
);

  logic      hund_v_r;
  ssd_hund_t hund_r;
  ssd_hund_t hund_nxt;
  logic      dec_v_r;
  ssd_dec_t  dec_r;
  ssd_dec_t  dec_nxt;
  logic      hund_rdy;
  logic      dec_rdy;
  logic [15:0] hund_prod;
  logic [9:0]  hund_sub;
  logic [14:0] tens_prod;
  logic [6:0]  tens_sub;

  assign dec_rdy  = !dec_v_r || out_ready;
  assign hund_rdy = !hund_v_r || dec_rdy;
  assign in_ready = hund_rdy;

  // hundreds digit by reciprocal multiply, remainder below one hundred
  always_comb begin
    hund_prod       = 16'(in_data.mag) * 16'(RECIP_100);
    hund_nxt.tenths = in_data.tenths;
    hund_nxt.neg    = in_data.neg;
    hund_nxt.ovf    = in_data.ovf;
    hund_nxt.lt10   = (in_data.mag < 10'd10);
    hund_nxt.lt100  = (in_data.mag < 10'd100);
    hund_nxt.hund   = hund_prod[15:12];
    hund_sub        = in_data.mag - (10'(hund_prod[15:12]) * 10'd100);
    hund_nxt.rem    = hund_sub[6:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hund_v_r <= 1'b0;
    end else if (hund_rdy) begin
      hund_v_r <= in_valid;
    end
    if (hund_rdy && in_valid) begin
      hund_r <= hund_nxt;
    end
  end

  // tens and ones from the remainder
  always_comb begin
    tens_prod      = 15'(hund_r.rem) * 15'(RECIP_10);
    dec_nxt.tenths = hund_r.tenths;
    dec_nxt.neg    = hund_r.neg;
    dec_nxt.ovf    = hund_r.ovf;
    dec_nxt.lt10   = hund_r.lt10;
    dec_nxt.lt100  = hund_r.lt100;
    dec_nxt.hund   = hund_r.hund;
    dec_nxt.tens   = tens_prod[14:11];
    tens_sub       = hund_r.rem - (7'(tens_prod[14:11]) * 7'd10);
    dec_nxt.ones   = tens_sub[3:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_v_r <= 1'b0;
    end else if (dec_rdy) begin
      dec_v_r <= hund_v_r;
    end
    if (dec_rdy && hund_v_r) begin
      dec_r <= dec_nxt;
    end
  end

  assign out_valid = dec_v_r;
  assign out_data  = dec_r;

endmodule

// ----- hdl/ssd_pattern.sv -----
module ssd_pattern import ssd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ssd_dec_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output ssd_pat_t out_data
);

  logic       pat_v_r;
  ssd_pat_t   pat_r;
  ssd_pat_t   pat_nxt;
  logic       pat_rdy;
  logic [7:0] sign_seg;
  logic [7:0] h_seg;
  logic [7:0] t_seg;
  logic [7:0] o_seg;

  assign pat_rdy  = !pat_v_r || out_ready;
  assign in_ready = pat_rdy;

  // place sign, digits and point per mode
  always_comb begin
    sign_seg = in_data.neg ? SEG_MINUS : SEG_BLANK;
    h_seg    = seg_of(in_data.hund);
    t_seg    = seg_of(in_data.tens);
    o_seg    = seg_of(in_data.ones);
    pat_nxt  = '0;
    priority if (in_data.ovf) begin
      pat_nxt = {NUM_POS{SEG_MINUS}};
    end else if (in_data.tenths) begin
      pat_nxt[0] = in_data.lt100 ? SEG_BLANK : sign_seg;
      pat_nxt[1] = in_data.lt100 ? sign_seg : h_seg;
      pat_nxt[2] = t_seg | SEG_POINT;
      pat_nxt[3] = o_seg;
    end else if (in_data.lt10) begin
      pat_nxt[0] = SEG_BLANK;
      pat_nxt[1] = SEG_BLANK;
      pat_nxt[2] = sign_seg;
      pat_nxt[3] = o_seg;
    end else if (in_data.lt100) begin
      pat_nxt[0] = SEG_BLANK;
      pat_nxt[1] = sign_seg;
      pat_nxt[2] = t_seg;
      pat_nxt[3] = o_seg;
    end else begin
      pat_nxt[0] = sign_seg;
      pat_nxt[1] = h_seg;
      pat_nxt[2] = t_seg;
      pat_nxt[3] = o_seg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_v_r <= 1'b0;
    end else if (pat_rdy) begin
      pat_v_r <= in_valid;
    end
    if (pat_rdy && in_valid) begin
      pat_r <= pat_nxt;
    end
  end

  assign out_valid = pat_v_r;
  assign out_data  = pat_r;

endmodule

// ----- hdl/ssd_serial.sv -----
module ssd_serial import ssd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  ssd_pat_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_pos,
  output logic [7:0] out_seg,
  output logic       out_last
);

  logic       ser_v_r;
  logic [1:0] pos_r;
  ssd_pat_t   hold_r;
  logic       load;
  logic       last;

  assign last     = (pos_r == POS_LAST);
  assign load     = !ser_v_r || (last && !out_stall);
  assign in_ready = load;

  // hold four patterns and step through the positions
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_v_r <= 1'b0;
      pos_r   <= '0;
    end else if (load) begin
      ser_v_r <= in_valid;
      pos_r   <= '0;
    end else if (!out_stall) begin
      pos_r   <= pos_r + 2'd1;
    end
    if (load && in_valid) begin
      hold_r <= in_data;
    end
  end

  assign out_valid = ser_v_r;
  assign out_pos   = pos_r;
  assign out_seg   = hold_r[pos_r];
  assign out_last  = last;

endmodule
